FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the router design file.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/hktr_pkg.sv
// ----------------------------------------------------------------------------
// hktr_pkg
// Shared constants, field widths and helpers of the Hamming top-k router.
// ----------------------------------------------------------------------------
package hktr_pkg;

    // Parameter defaults
    localparam int ENTRIES_DEF  = 1024;
    localparam int TOP_K_DEF    = 6;
    localparam int SIG_BITS_DEF = 32;

    // Fixed field widths
    localparam int IDX_W      = 10;
    localparam int SIG_W      = 32;
    localparam int CNT_W      = 11;
    localparam int RANK_W     = 3;
    localparam int DIST_W     = 6;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Popcount of a 64-bit word: count each byte, then add the byte counts.
    function automatic logic [6:0] popcount64(input logic [63:0] v);
        logic [3:0] byte_cnt [8];
        logic [6:0] sum;
        sum = '0;
        for (int b = 0; b < 8; b++)
        begin
            byte_cnt[b] = '0;
            for (int i = 0; i < 8; i++)
            begin
                byte_cnt[b] = byte_cnt[b] + {3'b000, v[8*b+i]};
            end
        end
        for (int b = 0; b < 8; b++)
        begin
            sum = sum + {3'b000, byte_cnt[b]};
        end
        return sum;
    endfunction

endpackage

FILE: hdl/hktr_ram.sv
// ----------------------------------------------------------------------------
// hktr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hktr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/hamming_top_k_router.sv
// ----------------------------------------------------------------------------
// hamming_top_k_router: a query scans the first n table entries (n = entry_count
// capped at ENTRIES, one table read per cycle), then gives TOP_K result words at
// one per cycle while m_axis_tready is high. The input reopens once the list
// moves to the result buffer; a scan that ends while the buffer is still busy
// holds the input. Reset clears control state, sets entry_count to 1.
// ----------------------------------------------------------------------------
module hamming_top_k_router
    import hktr_pkg::*;
#(
    parameter int ENTRIES        = ENTRIES_DEF,
    parameter int TOP_K          = TOP_K_DEF,
    parameter int SIGNATURE_BITS = SIG_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: entry_count
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    // Input words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: entry_index[9:0], entry_signature[41:10], query_signature[73:42]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[0]
    input  logic [0:0]            s_axis_tuser,
    // Result words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: rank[2:0], route_id[12:3], distance[18:13]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: found[0]
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = $clog2(SIGNATURE_BITS + 1);
    localparam int KW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Input field unpacking
    logic [IDX_W-1:0] in_index;
    logic [SIG_W-1:0] in_entry_sig;
    logic [SIG_W-1:0] in_query_sig;
    op_t              in_op;

    assign in_index     = s_axis_tdata[IDX_W-1:0];
    assign in_entry_sig = s_axis_tdata[IDX_W+SIG_W-1:IDX_W];
    assign in_query_sig = s_axis_tdata[IDX_W+2*SIG_W-1:IDX_W+SIG_W];
    assign in_op        = op_t'(s_axis_tuser[0]);

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic               s1_v_reg, s1_v_next;
    logic               s2_v_reg, s2_v_next;
    logic [TOP_K-1:0]   slot_valid_reg, slot_valid_next;
    logic               ob_busy_reg, ob_busy_next;
    logic [KW-1:0]      ob_rank_reg, ob_rank_next;
    logic [TOP_K-1:0]   ob_valid_reg, ob_valid_next;

    // Payload registers
    logic [SIGNATURE_BITS-1:0] q_reg, q_next;
    logic [AW-1:0]      s1_id_reg, s1_id_next;
    logic [AW-1:0]      s2_id_reg, s2_id_next;
    logic [DW-1:0]      s2_dist_reg, s2_dist_next;
    logic [AW-1:0]      slot_id_reg [TOP_K];
    logic [AW-1:0]      slot_id_next [TOP_K];
    logic [DW-1:0]      slot_dist_reg [TOP_K];
    logic [DW-1:0]      slot_dist_next [TOP_K];
    logic [AW-1:0]      ob_id_reg [TOP_K];
    logic [AW-1:0]      ob_id_next [TOP_K];
    logic [DW-1:0]      ob_dist_reg [TOP_K];
    logic [DW-1:0]      ob_dist_next [TOP_K];

    // Table memory
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [SIGNATURE_BITS-1:0] ram_wdata;
    logic                      ram_re;
    logic [SIGNATURE_BITS-1:0] ram_rdata;

    logic             in_acc;
    logic             out_acc;
    logic             drained;
    logic [TOP_K-1:0] better;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    assign ram_we    = in_acc && (in_op == OP_LOAD) && (32'(in_index) < 32'(ENTRIES));
    assign ram_waddr = AW'(in_index);
    assign ram_wdata = SIGNATURE_BITS'(in_entry_sig);
    assign ram_re    = (state_reg == ST_SCAN) && (rd_cnt_reg < n_reg);
    assign drained   = !ram_re && !s1_v_reg && !s2_v_reg;

    hktr_ram #(
        .WIDTH (SIGNATURE_BITS),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // A slot loses its place when it is empty or strictly farther.
    always_comb
    begin
        for (int j = 0; j < TOP_K; j++)
        begin
            better[j] = !slot_valid_reg[j] || (slot_dist_reg[j] > s2_dist_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        n_next           = n_reg;
        rd_cnt_next      = rd_cnt_reg;
        s1_v_next        = ram_re;
        s2_v_next        = s1_v_reg;
        slot_valid_next  = slot_valid_reg;
        ob_busy_next     = ob_busy_reg;
        ob_rank_next     = ob_rank_reg;
        ob_valid_next    = ob_valid_reg;
        q_next           = q_reg;
        s1_id_next       = rd_cnt_reg[AW-1:0];
        s2_id_next       = s1_id_reg;
        s2_dist_next     = DW'(popcount64(64'(ram_rdata ^ q_reg)));
        slot_id_next     = slot_id_reg;
        slot_dist_next   = slot_dist_reg;
        ob_id_next       = ob_id_reg;
        ob_dist_next     = ob_dist_reg;

        if (cfg_valid && cfg_ready)
        begin
            entry_count_next = cfg_data;
        end

        // Insert the distance from the pipe into the sorted slots.
        if (s2_v_reg)
        begin
            if (better[0])
            begin
                slot_id_next[0]    = s2_id_reg;
                slot_dist_next[0]  = s2_dist_reg;
                slot_valid_next[0] = 1'b1;
            end
            for (int j = 1; j < TOP_K; j++)
            begin
                if (better[j] && better[j-1])
                begin
                    slot_id_next[j]    = slot_id_reg[j-1];
                    slot_dist_next[j]  = slot_dist_reg[j-1];
                    slot_valid_next[j] = slot_valid_reg[j-1];
                end
                else if (better[j])
                begin
                    slot_id_next[j]    = s2_id_reg;
                    slot_dist_next[j]  = s2_dist_reg;
                    slot_valid_next[j] = 1'b1;
                end
            end
        end

        // Drain the result buffer, one word per handshake.
        if (out_acc)
        begin
            for (int j = 0; j < TOP_K - 1; j++)
            begin
                ob_id_next[j]    = ob_id_reg[j+1];
                ob_dist_next[j]  = ob_dist_reg[j+1];
                ob_valid_next[j] = ob_valid_reg[j+1];
            end
            ob_rank_next = ob_rank_reg + KW'(1);
            if (ob_rank_reg == KW'(TOP_K - 1))
            begin
                ob_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_op == OP_QUERY))
                begin
                    q_next          = SIGNATURE_BITS'(in_query_sig);
                    slot_valid_next = '0;
                    rd_cnt_next     = '0;
                    if (32'(entry_count_reg) > 32'(ENTRIES))
                    begin
                        n_next = CW'(ENTRIES);
                    end
                    else
                    begin
                        n_next = CW'(entry_count_reg);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (ram_re)
                begin
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                end
                // Hand the finished list to the result buffer once it is free.
                if (drained && !ob_busy_reg)
                begin
                    ob_id_next    = slot_id_reg;
                    ob_dist_next  = slot_dist_reg;
                    ob_valid_next = slot_valid_reg;
                    ob_rank_next  = '0;
                    ob_busy_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= CNT_W'(1);
            n_reg           <= '0;
            rd_cnt_reg      <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            slot_valid_reg  <= '0;
            ob_busy_reg     <= 1'b0;
            ob_rank_reg     <= '0;
            ob_valid_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            n_reg           <= n_next;
            rd_cnt_reg      <= rd_cnt_next;
            s1_v_reg        <= s1_v_next;
            s2_v_reg        <= s2_v_next;
            slot_valid_reg  <= slot_valid_next;
            ob_busy_reg     <= ob_busy_next;
            ob_rank_reg     <= ob_rank_next;
            ob_valid_reg    <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        s1_id_reg     <= s1_id_next;
        s2_id_reg     <= s2_id_next;
        s2_dist_reg   <= s2_dist_next;
        slot_id_reg   <= slot_id_next;
        slot_dist_reg <= slot_dist_next;
        ob_id_reg     <= ob_id_next;
        ob_dist_reg   <= ob_dist_next;
    end

    // Result word from the head of the buffer; empty slots read as zero.
    logic [IDX_W-1:0]  out_id;
    logic [DIST_W-1:0] out_dist;

    assign out_id   = ob_valid_reg[0] ? IDX_W'(ob_id_reg[0]) : '0;
    assign out_dist = ob_valid_reg[0] ? DIST_W'(ob_dist_reg[0]) : '0;

    assign m_axis_tvalid = ob_busy_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - RANK_W - IDX_W - DIST_W)'(0),
                            out_dist, out_id, RANK_W'(ob_rank_reg)};
    assign m_axis_tuser  = ob_valid_reg[0];
    assign m_axis_tlast  = (ob_rank_reg == KW'(TOP_K - 1));

`include "assert_macros.svh"

    `ASSERT_NEVER(a_slots_packed,
        ((slot_valid_reg + TOP_K'(1)) & slot_valid_reg) != '0,
        "filled slots are not a prefix of the list")
    `ASSERT_CLK(a_read_in_range, ram_re |-> (rd_cnt_reg < n_reg) && (n_reg <= CW'(ENTRIES)),
        "table read beyond the scan length")
    `ASSERT_CLK(a_last_ends_burst, (out_acc && m_axis_tlast) |=> !m_axis_tvalid,
        "result buffer still busy after the final word")
    `ASSERT_CLK(a_query_starts_scan,
        (in_acc && (in_op == OP_QUERY)) |=> (state_reg == ST_SCAN) && (rd_cnt_reg == '0),
        "query accepted without a fresh scan")

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for hamming_top_k_router
// Drives load and query words into the router and keeps its own copy of the
// signature table and entry count. Each query's six ranked result words are
// worked out from that copy when the query is accepted, and are then checked
// field by field against the words the router returns. Directed cases come
// first, then a partly loaded table, random traffic under three idling
// patterns, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import hktr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = TOP_K_DEF;
    localparam int ENTRY_LIMIT    = ENTRIES_DEF;
    localparam int LOADED_ENTRIES = 64;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SILENT_LIMIT   = 20000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed
    {
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  route_id;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              last;
    } route_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: entry_index, entry_signature, query_signature
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: operation
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: rank, route_id, distance
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: found
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    logic [SIG_W-1:0] signature_copy [ENTRY_LIMIT];
    int               scan_count;
    route_t           predicted_routes [$];
    int               mismatch_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               recv_hold_left;
    int               silent_cycles;

    hamming_top_k_router DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Scan the first entries in index order and keep the nearest, stable on ties.
    function automatic void rank_nearest(input logic [SIG_W-1:0] query);
        logic [IDX_W-1:0]  ids   [SLOTS];
        logic [DIST_W-1:0] dists [SLOTS];
        bit                used  [SLOTS];
        logic [DIST_W-1:0] d;
        route_t            r;
        int                n;
        int                j;
        n = (scan_count > ENTRY_LIMIT) ? ENTRY_LIMIT : scan_count;
        for (int k = 0; k < SLOTS; k++)
        begin
            ids[k]   = '0;
            dists[k] = '1;
            used[k]  = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            d = DIST_W'($countones(query ^ signature_copy[i]));
            j = SLOTS - 1;
            if (used[j] && dists[j] <= d)
                continue;
            while (j > 0 && (!used[j-1] || dists[j-1] > d))
            begin
                ids[j]   = ids[j-1];
                dists[j] = dists[j-1];
                used[j]  = used[j-1];
                j--;
            end
            ids[j]   = IDX_W'(i);
            dists[j] = d;
            used[j]  = 1'b1;
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            r.rank     = RANK_W'(k);
            r.route_id = used[k] ? ids[k] : '0;
            r.distance = used[k] ? dists[k] : '0;
            r.found    = used[k];
            r.last     = (k == SLOTS - 1);
            predicted_routes.push_back(r);
        end
    endfunction

    task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
                             input logic [SIG_W-1:0] entry_sig,
                             input logic [SIG_W-1:0] query_sig);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W-IDX_W-2*SIG_W){1'b0}}, query_sig, entry_sig, idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == OP_LOAD)
            signature_copy[idx] = entry_sig;
        else
            rank_nearest(query_sig);
    endtask

    task automatic send_load(input int idx, input logic [SIG_W-1:0] sig);
        send_word(OP_LOAD, IDX_W'(idx), sig, $urandom);
    endtask

    task automatic send_query(input logic [SIG_W-1:0] sig);
        send_word(OP_QUERY, IDX_W'($urandom), $urandom, sig);
    endtask

    // Drop valid, wait out every predicted word, then let a trailing load settle.
    task automatic drain_routes();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (predicted_routes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scan_count = value & ((1 << CNT_W) - 1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_hold_left = recv_hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        route_t got;
        route_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.rank     = m_axis_tdata[2:0];
            got.route_id = m_axis_tdata[12:3];
            got.distance = m_axis_tdata[18:13];
            got.found    = m_axis_tuser[0];
            got.last     = m_axis_tlast;
            if (predicted_routes.size() == 0)
            begin
                $error("result word with nothing outstanding: rank %0d route_id %0d",
                       got.rank, got.route_id);
                mismatch_count++;
            end
            else
            begin
                want = predicted_routes.pop_front();
                if (got.rank !== want.rank)
                begin
                    $error("rank: expected %0d, got %0d", want.rank, got.rank);
                    mismatch_count++;
                end
                if (got.route_id !== want.route_id)
                begin
                    $error("route_id: expected %0d, got %0d", want.route_id, got.route_id);
                    mismatch_count++;
                end
                if (got.distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d", want.distance, got.distance);
                    mismatch_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    mismatch_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Longest silence: the long output hold.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            silent_cycles <= 0;
        else if (silent_cycles >= SILENT_LIMIT)
        begin
            $display("** hamming_top_k_router: FAILED **");
            $finish;
        end
        else
            silent_cycles <= silent_cycles + 1;
    end

    // Entry count comes out of reset as one.
    task automatic test_reset_count();
        send_load(0, 32'hFFFF_FFFF);
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        drain_routes();
    endtask

    task automatic test_zero_count();
        write_entry_count(0);
        send_query(32'h1234_5678);
        drain_routes();
    endtask

    // Equal distances keep the lower index; the last tie falls off the list.
    task automatic test_ranking_ties();
        send_load(1, 32'h0000_0000);
        send_load(2, 32'h0000_000F);
        send_load(3, 32'h0000_000F);
        send_load(4, 32'hF000_0000);
        send_load(5, 32'h0000_0001);
        send_load(6, 32'h8000_0000);
        send_load(7, 32'h0000_0003);
        drain_routes();
        write_entry_count(3);
        send_query(32'h0000_0000);
        drain_routes();
        write_entry_count(8);
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_000F);
        drain_routes();
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < LOADED_ENTRIES; i++)
            send_load(i, (i % 16 == 0) ? 32'h0 : 32'($urandom));
        drain_routes();
        write_entry_count(LOADED_ENTRIES);
        send_query($urandom);
        send_query(32'h0000_0000);
        drain_routes();
    endtask

    // Hold the output off while queries keep coming, so the input backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_entry_count(4);
        @(posedge clk);
        recv_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 12; i++)
            send_query($urandom);
        // pause the sender until every word is back
        drain_routes();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int               sent;
        int               pick;
        int               span;
        int               idx;
        logic [SIG_W-1:0] sig;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            drain_routes();
            pick = $urandom_range(19);
            if (pick == 0)
                write_entry_count(0);
            else if (pick < 6)
                write_entry_count($urandom_range(17, LOADED_ENTRIES));
            else
                write_entry_count($urandom_range(1, 16));
            span = (scan_count == 0 || scan_count > LOADED_ENTRIES) ? LOADED_ENTRIES
                 : scan_count;
            for (int i = 0; i < 12 && sent < n_items; i++)
            begin
                if ($urandom_range(9) < 3)
                begin
                    idx = ($urandom_range(3) == 0) ? $urandom_range(ENTRY_LIMIT - 1)
                        : $urandom_range((span + 3 < ENTRY_LIMIT) ? span + 3
                                                                   : ENTRY_LIMIT - 1);
                    sig = ($urandom_range(2) == 0)
                        ? signature_copy[$urandom_range(span - 1)] : 32'($urandom);
                    send_load(idx, sig);
                end
                else
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        sig = '0;
                    else if (pick == 1)
                        sig = '1;
                    else if (pick < 5)
                        sig = signature_copy[$urandom_range(span - 1)]
                            ^ (($urandom_range(1) == 0) ? 32'h0
                                                        : (32'h1 << $urandom_range(31)));
                    else
                        sig = $urandom;
                    send_query(sig);
                end
                sent++;
            end
        end
        drain_routes();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        scan_count     = 1;
        mismatch_count = 0;
        send_idle_pct  = 26;
        recv_idle_pct  = 63;
        recv_hold_left = 0;
        silent_cycles  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_count();
        test_zero_count();
        test_ranking_ties();
        test_table_fill();
        test_random_traffic(26, 63, 42);
        test_random_traffic(63, 26, 42);
        test_random_traffic(0, 0, 42);
        test_backpressure();

        if (mismatch_count == 0)
            $display("** hamming_top_k_router: PASSED **");
        else
            $display("** hamming_top_k_router: FAILED **");
        $finish;
    end

endmodule
